### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define SIT_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Clocked check that also runs during reset.
`define SIT_ASSERT_NORST(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

### src/sit_pkg.sv
package sit_pkg;

  localparam int COORD_BITS_DEF = 16;

  // Four orientation tests: B start and B end against A, A start and A end against B.
  localparam int NUM_TURN = 4;
  localparam int NUM_PROD = 2 * NUM_TURN;

  // Difference vector layout: the two segment directions, then two terms per test.
  localparam int D_AX   = 0;
  localparam int D_AY   = 1;
  localparam int D_BX   = 2;
  localparam int D_BY   = 3;
  localparam int D_TURN = 4;
  localparam int NUM_DIFF = D_TURN + 2 * NUM_TURN;

  typedef enum logic [1:0] {
    ORIENT_COLLINEAR = 2'd0,
    ORIENT_CW        = 2'd1,
    ORIENT_CCW       = 2'd2
  } orient_t;

endpackage

### src/sit_req_if.sv
interface sit_req_if #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_a_start_x;
  logic signed [COORD_BITS-1:0] seg_a_start_y;
  logic signed [COORD_BITS-1:0] seg_a_end_x;
  logic signed [COORD_BITS-1:0] seg_a_end_y;
  logic signed [COORD_BITS-1:0] seg_b_start_x;
  logic signed [COORD_BITS-1:0] seg_b_start_y;
  logic signed [COORD_BITS-1:0] seg_b_end_x;
  logic signed [COORD_BITS-1:0] seg_b_end_y;

  modport source (
    output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    input  ready
  );

  modport sink (
    input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    output ready
  );
endinterface

### src/sit_rsp_if.sv
interface sit_rsp_if;
  logic valid;
  logic ready;
  logic segments_cross;

  modport source (
    output valid, segments_cross,
    input  ready
  );

  modport sink (
    input  valid, segments_cross,
    output ready
  );
endinterface

### src/sit_diff.sv
`include "assert_macros.svh"

module sit_diff #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  sit_req_if.sink                    req,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic signed [COORD_BITS:0] diff_o [sit_pkg::NUM_DIFF],
  output logic [sit_pkg::NUM_TURN-1:0] box_o
);

  localparam int CB = COORD_BITS;

  logic signed [CB:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  logic signed [CB:0] diff_nxt [sit_pkg::NUM_DIFF];
  logic signed [CB:0] diff_r   [sit_pkg::NUM_DIFF];
  logic [sit_pkg::NUM_TURN-1:0] box_nxt, box_r;
  logic valid_r;

  // True when m lies in the closed range spanned by e0 and e1, in either order.
  function automatic logic between(input logic signed [CB:0] m,
                                   input logic signed [CB:0] e0,
                                   input logic signed [CB:0] e1);
    return (m <= e0 || m <= e1) && (m >= e0 || m >= e1);
  endfunction

  assign ax0 = {req.seg_a_start_x[CB-1], req.seg_a_start_x};
  assign ay0 = {req.seg_a_start_y[CB-1], req.seg_a_start_y};
  assign ax1 = {req.seg_a_end_x[CB-1],   req.seg_a_end_x};
  assign ay1 = {req.seg_a_end_y[CB-1],   req.seg_a_end_y};
  assign bx0 = {req.seg_b_start_x[CB-1], req.seg_b_start_x};
  assign by0 = {req.seg_b_start_y[CB-1], req.seg_b_start_y};
  assign bx1 = {req.seg_b_end_x[CB-1],   req.seg_b_end_x};
  assign by1 = {req.seg_b_end_y[CB-1],   req.seg_b_end_y};

  always_comb begin
    diff_nxt[sit_pkg::D_AX]       = ax1 - ax0;
    diff_nxt[sit_pkg::D_AY]       = ay1 - ay0;
    diff_nxt[sit_pkg::D_BX]       = bx1 - bx0;
    diff_nxt[sit_pkg::D_BY]       = by1 - by0;
    // Each test compares the pivot (segment end) to the third point.
    diff_nxt[sit_pkg::D_TURN + 0] = bx0 - ax1;
    diff_nxt[sit_pkg::D_TURN + 1] = by0 - ay1;
    diff_nxt[sit_pkg::D_TURN + 2] = bx1 - ax1;
    diff_nxt[sit_pkg::D_TURN + 3] = by1 - ay1;
    diff_nxt[sit_pkg::D_TURN + 4] = ax0 - bx1;
    diff_nxt[sit_pkg::D_TURN + 5] = ay0 - by1;
    diff_nxt[sit_pkg::D_TURN + 6] = ax1 - bx1;
    diff_nxt[sit_pkg::D_TURN + 7] = ay1 - by1;

    box_nxt[0] = between(bx0, ax0, ax1) && between(by0, ay0, ay1);
    box_nxt[1] = between(bx1, ax0, ax1) && between(by1, ay0, ay1);
    box_nxt[2] = between(ax0, bx0, bx1) && between(ay0, by0, by1);
    box_nxt[3] = between(ax1, bx0, bx1) && between(ay1, by0, by1);
  end

  assign req.ready = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req.ready) begin
      valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      diff_r <= diff_nxt;
      box_r  <= box_nxt;
    end
  end

  assign valid_o = valid_r;
  assign diff_o  = diff_r;
  assign box_o   = box_r;

  `SIT_ASSERT(a_diff_shared_point, clk, rst_n, (req.valid && req.ready && req.seg_b_start_x == req.seg_a_start_x && req.seg_b_start_y == req.seg_a_start_y) |=> box_r[0], "shared start point missed by box test")
  `SIT_ASSERT(a_diff_stall_hold, clk, rst_n, (valid_r && !ready_i) |=> (valid_r && $stable(box_r)), "stalled difference stage lost its request")

endmodule

### src/sit_mult.sv
`include "assert_macros.svh"

module sit_mult #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic signed [COORD_BITS:0]       diff_i [sit_pkg::NUM_DIFF],
  input  logic [sit_pkg::NUM_TURN-1:0]     box_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [2*COORD_BITS+1:0]   prod_o [sit_pkg::NUM_PROD],
  output logic [sit_pkg::NUM_TURN-1:0]     box_o
);

  localparam int CB = COORD_BITS;
  localparam int PW = 2 * COORD_BITS + 2;

  logic signed [PW-1:0] prod_nxt [sit_pkg::NUM_PROD];
  logic signed [PW-1:0] prod_r   [sit_pkg::NUM_PROD];
  logic [sit_pkg::NUM_TURN-1:0] box_r;
  logic valid_r;

  // The first two tests turn about segment A, the last two about segment B.
  always_comb begin
    for (int k = 0; k < sit_pkg::NUM_TURN; k++) begin
      prod_nxt[2*k]   = PW'(k < 2 ? diff_i[sit_pkg::D_AY] : diff_i[sit_pkg::D_BY]) *
                        PW'(diff_i[sit_pkg::D_TURN + 2*k]);
      prod_nxt[2*k+1] = PW'(k < 2 ? diff_i[sit_pkg::D_AX] : diff_i[sit_pkg::D_BX]) *
                        PW'(diff_i[sit_pkg::D_TURN + 2*k + 1]);
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      prod_r <= prod_nxt;
      box_r  <= box_i;
    end
  end

  assign valid_o = valid_r;
  assign prod_o  = prod_r;
  assign box_o   = box_r;

  `SIT_ASSERT(a_mult_sign, clk, rst_n, (valid_i && ready_o && diff_i[sit_pkg::D_AY] != '0 && diff_i[sit_pkg::D_TURN] != '0) |=> (prod_r[0][PW-1] == ($past(diff_i[sit_pkg::D_AY][CB]) ^ $past(diff_i[sit_pkg::D_TURN][CB]))), "cross product term has the wrong sign")

endmodule

### src/sit_decide.sv
`include "assert_macros.svh"

module sit_decide #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [2*COORD_BITS+1:0] prod_i [sit_pkg::NUM_PROD],
  input  logic [sit_pkg::NUM_TURN-1:0]   box_i,
  sit_rsp_if.source                      rsp
);

  sit_pkg::orient_t orient_nxt [sit_pkg::NUM_TURN];
  sit_pkg::orient_t orient_r   [sit_pkg::NUM_TURN];
  logic [sit_pkg::NUM_TURN-1:0] box3_r;
  logic valid3_r, valid4_r;
  logic ready4;
  logic hit_nxt, hit_r;

  // Orientation stage: one wide signed compare per test.
  always_comb begin
    for (int k = 0; k < sit_pkg::NUM_TURN; k++) begin
      if (prod_i[2*k] == prod_i[2*k+1]) begin
        orient_nxt[k] = sit_pkg::ORIENT_COLLINEAR;
      end else if (prod_i[2*k] > prod_i[2*k+1]) begin
        orient_nxt[k] = sit_pkg::ORIENT_CW;
      end else begin
        orient_nxt[k] = sit_pkg::ORIENT_CCW;
      end
    end
  end

  // General crossing, or a collinear end point that sits inside the other segment's box.
  always_comb begin
    hit_nxt = (orient_r[0] != orient_r[1] && orient_r[2] != orient_r[3]);
    for (int k = 0; k < sit_pkg::NUM_TURN; k++) begin
      hit_nxt = hit_nxt || (orient_r[k] == sit_pkg::ORIENT_COLLINEAR && box3_r[k]);
    end
  end

  assign ready4  = !valid4_r || rsp.ready;
  assign ready_o = !valid3_r || ready4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid3_r <= 1'b0;
      valid4_r <= 1'b0;
    end else begin
      if (ready_o) begin
        valid3_r <= valid_i;
      end
      if (ready4) begin
        valid4_r <= valid3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      orient_r <= orient_nxt;
      box3_r   <= box_i;
    end
    if (valid3_r && ready4) begin
      hit_r <= hit_nxt;
    end
  end

  assign rsp.valid          = valid4_r;
  assign rsp.segments_cross = hit_r;

  `SIT_ASSERT_NORST(a_dec_reset_empty, clk, !rst_n |=> (!valid3_r && !valid4_r), "pipeline holds a request after reset")
  `SIT_ASSERT(a_dec_touch, clk, rst_n, (valid3_r && ready4 && orient_r[0] == sit_pkg::ORIENT_COLLINEAR && box3_r[0]) |=> hit_r, "touching end point not reported as a crossing")
  `SIT_ASSERT(a_dec_stall_hold, clk, rst_n, (valid3_r && !ready4) |=> valid3_r, "stalled orientation stage dropped its request")

endmodule

### src/segment_intersection_test.sv
// Channel   Direction  Handshake    Payload
// in_req    input      valid/ready  two segments, eight signed COORD_BITS coordinates
// out_rsp   output     valid/ready  segments_cross
//
// One request per cycle sustained while out_rsp.ready is high.
// The four stages are: differences and box tests, eight signed multipliers of
// COORD_BITS+1 bits each, the cross product compares, and the decision/output register.
// Reset is synchronous, active low, and clears only the stage valid bits.
// A stage holds its request while the next one is full and stalled, so in_req.ready
// falls only when all four stages are occupied and out_rsp.ready is low.
module segment_intersection_test #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sit_req_if.sink    in_req,
  sit_rsp_if.source  out_rsp
);

  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  logic signed [COORD_BITS:0]     s1_diff [sit_pkg::NUM_DIFF];
  logic signed [2*COORD_BITS+1:0] s2_prod [sit_pkg::NUM_PROD];
  logic [sit_pkg::NUM_TURN-1:0]   s1_box, s2_box;

  sit_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (in_req),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .diff_o  (s1_diff),
    .box_o   (s1_box)
  );

  sit_mult #(.COORD_BITS(COORD_BITS)) u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .diff_i  (s1_diff),
    .box_i   (s1_box),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .prod_o  (s2_prod),
    .box_o   (s2_box)
  );

  sit_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .prod_i  (s2_prod),
    .box_i   (s2_box),
    .rsp     (out_rsp)
  );

endmodule

### bench/segment_intersection_test_tb.sv
`timescale 1ns / 1ps

module segment_intersection_test_tb;

  localparam int CW = sit_pkg::COORD_BITS_DEF;
  localparam longint CMAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam int N_RANDOM = 1500;
  localparam int CALM_AT = N_RANDOM - 150;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t a0x, a0y, a1x, a1y;
    coord_t b0x, b0y, b1x, b1y;
  } seg_pair_t;

  typedef struct {
    longint x;
    longint y;
  } point_t;

  class cross_scoreboard;
    bit expected_cross[$];
    int n_requests;
    int n_checked;
    int n_cross;
    int n_errors;

    function sit_pkg::orient_t orientation(point_t a, point_t b, point_t c);
      longint lhs;
      longint rhs;
      lhs = (b.y - a.y) * (c.x - b.x);
      rhs = (b.x - a.x) * (c.y - b.y);
      if (lhs == rhs) return sit_pkg::ORIENT_COLLINEAR;
      return (lhs > rhs) ? sit_pkg::ORIENT_CW : sit_pkg::ORIENT_CCW;
    endfunction

    // True when m lies inside the box spanned by end points e0 and e1.
    function bit within_box(point_t e0, point_t m, point_t e1);
      longint lo_x, hi_x, lo_y, hi_y;
      lo_x = (e0.x < e1.x) ? e0.x : e1.x;
      hi_x = (e0.x > e1.x) ? e0.x : e1.x;
      lo_y = (e0.y < e1.y) ? e0.y : e1.y;
      hi_y = (e0.y > e1.y) ? e0.y : e1.y;
      return m.x >= lo_x && m.x <= hi_x && m.y >= lo_y && m.y <= hi_y;
    endfunction

    function bit segments_meet(seg_pair_t p);
      point_t a0, a1, b0, b1;
      sit_pkg::orient_t t1, t2, t3, t4;
      a0 = '{longint'(p.a0x), longint'(p.a0y)};
      a1 = '{longint'(p.a1x), longint'(p.a1y)};
      b0 = '{longint'(p.b0x), longint'(p.b0y)};
      b1 = '{longint'(p.b1x), longint'(p.b1y)};
      t1 = orientation(a0, a1, b0);
      t2 = orientation(a0, a1, b1);
      t3 = orientation(b0, b1, a0);
      t4 = orientation(b0, b1, a1);
      return (t1 != t2 && t3 != t4) ||
             (t1 == sit_pkg::ORIENT_COLLINEAR && within_box(a0, b0, a1)) ||
             (t2 == sit_pkg::ORIENT_COLLINEAR && within_box(a0, b1, a1)) ||
             (t3 == sit_pkg::ORIENT_COLLINEAR && within_box(b0, a0, b1)) ||
             (t4 == sit_pkg::ORIENT_COLLINEAR && within_box(b0, a1, b1));
    endfunction

    function void note_request(seg_pair_t p);
      n_requests++;
      expected_cross.push_back(segments_meet(p));
    endfunction

    function void check_result(logic actual);
      bit want;
      if (expected_cross.size() == 0) begin
        $error("segments_cross: expected nothing, actual %b", actual);
        n_errors++;
        return;
      end
      want = expected_cross.pop_front();
      n_checked++;
      if (want) n_cross++;
      if (actual !== want) begin
        $error("segments_cross: expected %b, actual %b", want, actual);
        n_errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm_tail;
  bit   quiet_stretch;

  sit_req_if #(.COORD_BITS(CW)) in_req ();
  sit_rsp_if                    out_rsp ();

  segment_intersection_test #(.COORD_BITS(CW)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  cross_scoreboard sb = new;

  function automatic coord_t sat_coord(longint v);
    if (v > CMAX) return coord_t'(CMAX);
    if (v < CMIN) return coord_t'(CMIN);
    return coord_t'(v);
  endfunction

  function automatic seg_pair_t make_pair(input longint ax0, ay0, ax1, ay1,
                                          bx0, by0, bx1, by1);
    make_pair = '{sat_coord(ax0), sat_coord(ay0), sat_coord(ax1), sat_coord(ay1),
                  sat_coord(bx0), sat_coord(by0), sat_coord(bx1), sat_coord(by1)};
  endfunction

  function automatic longint rnd_coord();
    coord_t v;
    v = coord_t'($urandom);
    return longint'(v);
  endfunction

  function automatic longint span_rand(longint r);
    return longint'($urandom_range(0, int'(2 * r))) - r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Accepted requests and results are both taken at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_req.valid && in_req.ready)
      sb.note_request('{in_req.seg_a_start_x, in_req.seg_a_start_y,
                        in_req.seg_a_end_x, in_req.seg_a_end_y,
                        in_req.seg_b_start_x, in_req.seg_b_start_y,
                        in_req.seg_b_end_x, in_req.seg_b_end_y});
    if (rst_n && out_rsp.valid && out_rsp.ready)
      sb.check_result(out_rsp.segments_cross);
  end

  // Result side: random stall bursts between runs of ready.
  initial begin
    out_rsp.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
        out_rsp.ready = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_rsp.ready = 1'b1;
        repeat ($urandom_range(0, 20)) @(negedge clk);
      end
    end
  end

  task automatic send_pair(input seg_pair_t p);
    @(negedge clk);
    in_req.valid         = 1'b1;
    in_req.seg_a_start_x = p.a0x;
    in_req.seg_a_start_y = p.a0y;
    in_req.seg_a_end_x   = p.a1x;
    in_req.seg_a_end_y   = p.a1y;
    in_req.seg_b_start_x = p.b0x;
    in_req.seg_b_start_y = p.b0y;
    in_req.seg_b_end_x   = p.b1x;
    in_req.seg_b_end_y   = p.b1y;
    do @(posedge clk); while (!in_req.ready);
    if (!calm_tail && !quiet_stretch && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 7)) begin
        @(negedge clk);
        in_req.valid = 1'b0;
      end
    end
  endtask

  task automatic random_pair(output seg_pair_t p);
    longint c [8];
    longint bx, by, dx, dy, mx, my, ex, ey, t, sw;
    case ($urandom_range(0, 9))
      0, 1: begin
        foreach (c[k]) c[k] = rnd_coord();
      end
      2, 3: begin
        foreach (c[k]) c[k] = span_rand(8);
      end
      4, 5: begin
        // Four points on one line, so both segments are collinear.
        bx = span_rand(1000);
        by = span_rand(1000);
        dx = span_rand(20);
        dy = span_rand(20);
        for (int k = 0; k < 4; k++) begin
          t = span_rand(20);
          c[2*k]   = bx + t * dx;
          c[2*k+1] = by + t * dy;
        end
      end
      6: begin
        // Segment B shrunk to a point on or next to the line of A.
        bx = span_rand(1000);
        by = span_rand(1000);
        dx = span_rand(20);
        dy = span_rand(20);
        t  = longint'($urandom_range(0, 12)) - 2;
        ex = ($urandom_range(0, 3) == 0) ? span_rand(1) : 0;
        ey = ($urandom_range(0, 3) == 0) ? span_rand(1) : 0;
        c[0] = bx;
        c[1] = by;
        c[2] = bx + 8 * dx;
        c[3] = by + 8 * dy;
        c[4] = bx + t * dx + ex;
        c[5] = by + t * dy + ey;
        c[6] = c[4];
        c[7] = c[5];
      end
      7: begin
        // B starts on an end of A or near its middle.
        for (int k = 0; k < 4; k++) c[k] = span_rand(10000);
        if ($urandom_range(0, 1)) begin
          c[4] = c[2];
          c[5] = c[3];
        end else begin
          c[4] = (c[0] + c[2]) / 2;
          c[5] = (c[1] + c[3]) / 2;
        end
        c[6] = span_rand(10000);
        c[7] = span_rand(10000);
      end
      8: begin
        foreach (c[k]) begin
          case ($urandom_range(0, 7))
            0: c[k] = CMIN;
            1: c[k] = CMIN + 1;
            2: c[k] = -1;
            3: c[k] = 0;
            4: c[k] = 1;
            5: c[k] = CMAX - 1;
            6: c[k] = CMAX;
            default: c[k] = rnd_coord();
          endcase
        end
      end
      default: begin
        // B passes through or close to the middle of a long segment A.
        for (int k = 0; k < 4; k++) c[k] = rnd_coord();
        mx = (c[0] + c[2]) / 2;
        my = (c[1] + c[3]) / 2;
        ex = span_rand(3000);
        ey = span_rand(3000);
        c[4] = mx + ex;
        c[5] = my + ey;
        c[6] = mx - ex;
        c[7] = my - ey;
      end
    endcase
    if ($urandom_range(0, 1)) begin
      for (int k = 0; k < 4; k++) begin
        sw = c[k];
        c[k] = c[k+4];
        c[k+4] = sw;
      end
    end
    p = make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endtask

  initial begin
    seg_pair_t pr;
    int n_directed;
    rst_n = 1'b0;
    calm_tail = 1'b0;
    quiet_stretch = 1'b0;
    in_req.valid = 1'b0;
    in_req.seg_a_start_x = '0;
    in_req.seg_a_start_y = '0;
    in_req.seg_a_end_x   = '0;
    in_req.seg_a_end_y   = '0;
    in_req.seg_b_start_x = '0;
    in_req.seg_b_start_y = '0;
    in_req.seg_b_end_x   = '0;
    in_req.seg_b_end_y   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Proper crossings, parallel and collinear lines, touching ends, T junctions.
    send_pair(make_pair(-100, -100, 100, 100, -100, 100, 100, -100));
    send_pair(make_pair(-1, -1, 1, 1, 1, -1, -1, 1));
    send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
    send_pair(make_pair(0, 0, 10, 0, 5, 0, 20, 0));
    send_pair(make_pair(0, 0, 10, 0, 11, 0, 20, 0));
    send_pair(make_pair(0, 0, 10, 0, 10, 0, 20, 0));
    send_pair(make_pair(10, 10, 0, 0, 20, 20, 5, 5));
    send_pair(make_pair(0, 0, 0, 10, 0, -1, 0, -10));
    send_pair(make_pair(0, 0, 10, 10, 10, 10, 20, 0));
    send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 10));
    send_pair(make_pair(0, 0, 10, 0, 5, 1, 5, 10));
    // Segments that have shrunk to single points.
    send_pair(make_pair(5, 5, 5, 5, 0, 0, 10, 10));
    send_pair(make_pair(5, 6, 5, 6, 0, 0, 10, 10));
    send_pair(make_pair(12, 12, 12, 12, 0, 0, 10, 10));
    send_pair(make_pair(3, 3, 3, 3, 3, 3, 3, 3));
    send_pair(make_pair(3, 3, 3, 3, 4, 3, 4, 3));
    // Coordinates at the ends of the range and alternating bit patterns.
    send_pair(make_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
    send_pair(make_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    send_pair(make_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_pair(make_pair(CMIN, CMIN, CMAX, CMIN, 0, CMIN, CMAX, CMIN));
    send_pair(make_pair(CMIN, CMIN, CMAX, CMAX - 1, CMAX, CMAX, CMAX, CMAX));
    send_pair(make_pair(CMIN, CMAX, CMAX, CMIN, 0, 0, CMAX, CMAX));
    send_pair(make_pair(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846));
    n_directed = 23;

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
      if (i == CALM_AT) calm_tail = 1'b1;
      random_pair(pr);
      send_pair(pr);
    end
    @(negedge clk);
    in_req.valid = 1'b0;

    while (sb.expected_cross.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d segment pairs: %0d hand-picked corner cases and %0d random pairs",
             sb.n_requests, n_directed, N_RANDOM);
    $display("over full-range, collinear, degenerate and shared-end mixes; %0d of %0d cross.",
             sb.n_cross, sb.n_checked);
    if (sb.n_errors == 0 && sb.expected_cross.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
